FILE: src/sde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sde_pkg;

  // Default stack depth for the top level
  localparam int DEF_STACK_DEPTH = 16;

  // Microprogram counter
  localparam int PC_W = 6;
  typedef logic [PC_W-1:0] pc_t;

  // Item kinds
  localparam logic [1:0] KIND_SET  = 2'd0;
  localparam logic [1:0] KIND_PUT  = 2'd1;
  localparam logic [1:0] KIND_PUSH = 2'd2;
  localparam logic [1:0] KIND_PULL = 2'd3;

  // Bytes of the escape sequence
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_M     = 8'h6D;

  // Flag indexes inside the attribute nibble
  localparam logic [7:0] FLAG_BOLD       = 8'd0;
  localparam logic [7:0] FLAG_UNDERSCORE = 8'd1;
  localparam logic [7:0] FLAG_BLINK      = 8'd2;
  localparam logic [7:0] FLAG_REVERSE    = 8'd3;

  // Colour digit for terminal default
  localparam logic [3:0] DIGIT_DEFAULT = 4'd9;
  localparam logic [3:0] FG_RESET      = 4'd7;
  localparam logic [3:0] BG_RESET      = 4'd0;

  // Datapath actions, one per control word
  typedef enum logic [3:0] {
    A_WAIT,
    A_NOP,
    A_START,
    A_POP,
    A_PUT,
    A_PUSH,
    A_ERR,
    A_EMIT,
    A_SEP,
    A_FLAG_FIRST,
    A_FLAG_OFF,
    A_FG_DIG,
    A_BG_DIG,
    A_END
  } act_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_ITEM,
    C_DISABLED,
    C_KIND_SET,
    C_KIND_PUT,
    C_KIND_PUSH,
    C_EMPTY,
    C_FULL,
    C_NO_CHANGE,
    C_FLAG_SAME,
    C_FLAG_ON,
    C_FG_SAME,
    C_BG_SAME
  } cond_t;

  typedef struct packed {
    act_t       act;
    cond_t      cond;
    logic [7:0] arg;     // constant byte or flag index
    pc_t        target;
  } ctl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic       item_valid;
    logic       disabled;
    logic [1:0] kind;
    logic       empty;
    logic       full;
    logic       no_change;
    logic [3:0] flag_same;
    logic [3:0] flag_on;
    logic       fg_same;
    logic       bg_same;
    logic       slot_free;
  } sts_t;

  // Program labels
  localparam pc_t L_IDLE  = 6'd0;
  localparam pc_t L_PUT   = 6'd8;
  localparam pc_t L_PUSH  = 6'd9;
  localparam pc_t L_ERR   = 6'd11;
  localparam pc_t L_UPD   = 6'd12;
  localparam pc_t L_BOLD  = 6'd15;
  localparam pc_t L_UND   = 6'd19;
  localparam pc_t L_BLINK = 6'd23;
  localparam pc_t L_REV   = 6'd27;
  localparam pc_t L_FG    = 6'd31;
  localparam pc_t L_BG    = 6'd35;
  localparam pc_t L_END   = 6'd39;

  function automatic ctl_t mk(act_t a, cond_t c, logic [7:0] arg, pc_t t);
    ctl_t w;
    w.act    = a;
    w.cond   = c;
    w.arg    = arg;
    w.target = t;
    return w;
  endfunction

  // Microprogram ROM
  function automatic ctl_t ucode(pc_t pc);
    ctl_t w;
    case (pc)
      // dispatch
      6'd0:  w = mk(A_WAIT,       C_NO_ITEM,   CH_NUL,          L_IDLE);
      6'd1:  w = mk(A_NOP,        C_DISABLED,  CH_NUL,          L_IDLE);
      6'd2:  w = mk(A_NOP,        C_KIND_SET,  CH_NUL,          L_UPD);
      6'd3:  w = mk(A_NOP,        C_KIND_PUT,  CH_NUL,          L_PUT);
      6'd4:  w = mk(A_NOP,        C_KIND_PUSH, CH_NUL,          L_PUSH);
      // pull
      6'd5:  w = mk(A_NOP,        C_EMPTY,     CH_NUL,          L_ERR);
      6'd6:  w = mk(A_NOP,        C_NEXT,      CH_NUL,          L_IDLE);
      6'd7:  w = mk(A_POP,        C_ALWAYS,    CH_NUL,          L_UPD);
      // put
      6'd8:  w = mk(A_PUT,        C_ALWAYS,    CH_NUL,          L_IDLE);
      // push
      6'd9:  w = mk(A_NOP,        C_FULL,      CH_NUL,          L_ERR);
      6'd10: w = mk(A_PUSH,       C_ALWAYS,    CH_NUL,          L_IDLE);
      // stack error
      6'd11: w = mk(A_ERR,        C_ALWAYS,    CH_NUL,          L_IDLE);
      // sequence head
      6'd12: w = mk(A_START,      C_NO_CHANGE, CH_NUL,          L_IDLE);
      6'd13: w = mk(A_EMIT,       C_NEXT,      CH_ESC,          L_IDLE);
      6'd14: w = mk(A_EMIT,       C_NEXT,      CH_LBR,          L_IDLE);
      // bold
      6'd15: w = mk(A_NOP,        C_FLAG_SAME, FLAG_BOLD,       L_UND);
      6'd16: w = mk(A_SEP,        C_NEXT,      FLAG_BOLD,       L_IDLE);
      6'd17: w = mk(A_FLAG_FIRST, C_FLAG_ON,   FLAG_BOLD,       L_UND);
      6'd18: w = mk(A_FLAG_OFF,   C_NEXT,      FLAG_BOLD,       L_IDLE);
      // underscore
      6'd19: w = mk(A_NOP,        C_FLAG_SAME, FLAG_UNDERSCORE, L_BLINK);
      6'd20: w = mk(A_SEP,        C_NEXT,      FLAG_UNDERSCORE, L_IDLE);
      6'd21: w = mk(A_FLAG_FIRST, C_FLAG_ON,   FLAG_UNDERSCORE, L_BLINK);
      6'd22: w = mk(A_FLAG_OFF,   C_NEXT,      FLAG_UNDERSCORE, L_IDLE);
      // blink
      6'd23: w = mk(A_NOP,        C_FLAG_SAME, FLAG_BLINK,      L_REV);
      6'd24: w = mk(A_SEP,        C_NEXT,      FLAG_BLINK,      L_IDLE);
      6'd25: w = mk(A_FLAG_FIRST, C_FLAG_ON,   FLAG_BLINK,      L_REV);
      6'd26: w = mk(A_FLAG_OFF,   C_NEXT,      FLAG_BLINK,      L_IDLE);
      // reverse
      6'd27: w = mk(A_NOP,        C_FLAG_SAME, FLAG_REVERSE,    L_FG);
      6'd28: w = mk(A_SEP,        C_NEXT,      FLAG_REVERSE,    L_IDLE);
      6'd29: w = mk(A_FLAG_FIRST, C_FLAG_ON,   FLAG_REVERSE,    L_FG);
      6'd30: w = mk(A_FLAG_OFF,   C_NEXT,      FLAG_REVERSE,    L_IDLE);
      // foreground
      6'd31: w = mk(A_NOP,        C_FG_SAME,   CH_NUL,          L_BG);
      6'd32: w = mk(A_SEP,        C_NEXT,      CH_NUL,          L_IDLE);
      6'd33: w = mk(A_EMIT,       C_NEXT,      CH_THREE,        L_IDLE);
      6'd34: w = mk(A_FG_DIG,     C_NEXT,      CH_NUL,          L_IDLE);
      // background
      6'd35: w = mk(A_NOP,        C_BG_SAME,   CH_NUL,          L_END);
      6'd36: w = mk(A_SEP,        C_NEXT,      CH_NUL,          L_IDLE);
      6'd37: w = mk(A_EMIT,       C_NEXT,      CH_FOUR,         L_IDLE);
      6'd38: w = mk(A_BG_DIG,     C_NEXT,      CH_NUL,          L_IDLE);
      // closing byte
      6'd39: w = mk(A_END,        C_ALWAYS,    CH_M,            L_IDLE);
      default: w = mk(A_WAIT,     C_ALWAYS,    CH_NUL,          L_IDLE);
    endcase
    return w;
  endfunction

  // Actions that put a byte into the output register
  function automatic logic is_emit(act_t a);
    logic r;
    case (a)
      A_ERR, A_EMIT, A_SEP, A_FLAG_FIRST, A_FLAG_OFF,
      A_FG_DIG, A_BG_DIG, A_END: r = 1'b1;
      default:                   r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] on_char(logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CH_ONE;
      2'd1:    c = CH_FOUR;
      2'd2:    c = CH_FIVE;
      default: c = CH_SEVEN;
    endcase
    return c;
  endfunction

  // Second byte of "22", "24", "25", "27"
  function automatic logic [7:0] off_char(logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CH_TWO;
      2'd1:    c = CH_FOUR;
      2'd2:    c = CH_FIVE;
      default: c = CH_SEVEN;
    endcase
    return c;
  endfunction

  // Codes above nine mean terminal default
  function automatic logic [3:0] clamp_digit(logic [3:0] v);
    return (v > DIGIT_DEFAULT) ? DIGIT_DEFAULT : v;
  endfunction

endpackage

`default_nettype wire

FILE: src/sde_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

module sde_sequencer (
  input  wire              clk,
  input  wire              rst,
  input  sde_pkg::sts_t    sts,
  output sde_pkg::ctl_t    ctl,
  output logic             go
);

  sde_pkg::pc_t pc;
  sde_pkg::pc_t pc_next;
  logic         take;

  // Control word of the current step
  assign ctl = sde_pkg::ucode(pc);

  // A byte step waits for a free output slot
  assign go = !sde_pkg::is_emit(ctl.act) || sts.slot_free;

  // Jump condition
  always_comb begin
    case (ctl.cond)
      sde_pkg::C_NEXT:      take = 1'b0;
      sde_pkg::C_ALWAYS:    take = 1'b1;
      sde_pkg::C_NO_ITEM:   take = !sts.item_valid;
      sde_pkg::C_DISABLED:  take = sts.disabled;
      sde_pkg::C_KIND_SET:  take = (sts.kind == sde_pkg::KIND_SET);
      sde_pkg::C_KIND_PUT:  take = (sts.kind == sde_pkg::KIND_PUT);
      sde_pkg::C_KIND_PUSH: take = (sts.kind == sde_pkg::KIND_PUSH);
      sde_pkg::C_EMPTY:     take = sts.empty;
      sde_pkg::C_FULL:      take = sts.full;
      sde_pkg::C_NO_CHANGE: take = sts.no_change;
      sde_pkg::C_FLAG_SAME: take = sts.flag_same[ctl.arg[1:0]];
      sde_pkg::C_FLAG_ON:   take = sts.flag_on[ctl.arg[1:0]];
      sde_pkg::C_FG_SAME:   take = sts.fg_same;
      sde_pkg::C_BG_SAME:   take = sts.bg_same;
      default:              take = 1'b0;
    endcase
  end

  always_comb begin
    pc_next = pc;
    if (go) begin
      pc_next = take ? ctl.target : pc + 1'b1;
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= sde_pkg::L_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/sde_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module sde_datapath #(
  parameter int STACK_DEPTH = sde_pkg::DEF_STACK_DEPTH
) (
  input  wire              clk,
  input  wire              rst,
  input  sde_pkg::ctl_t    ctl,
  input  wire              go,
  input  wire              colors_enabled,
  input  wire              s_tvalid,
  output logic             s_tready,
  input  wire  [15:0]      s_tdata,
  input  wire  [1:0]       s_tuser,
  output logic             m_tvalid,
  input  wire              m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast,
  output logic [0:0]       m_tuser,
  output sde_pkg::sts_t    sts
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Display state and target
  logic [3:0] cur_fg, cur_bg, cur_attr;
  logic [3:0] tgt_fg, tgt_bg, tgt_attr;
  logic [1:0] kind;
  logic       need_sep;

  // Stack
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_m1;
  logic [11:0]      mem [STACK_DEPTH];
  logic [11:0]      rd_data;

  logic       accept;
  logic       emit_now;
  logic [7:0] byte_next;
  logic       last_next;
  logic       err_next;
  logic [1:0] fidx;

  assign s_tready = (ctl.act == sde_pkg::A_WAIT);
  assign accept   = go && s_tready && s_tvalid;
  assign count_m1 = count - 1'b1;
  assign fidx     = ctl.arg[1:0];

  // Item decode and target at accept, target from the stack top on a pop
  always_ff @(posedge clk) begin
    if (accept) begin
      kind     <= s_tuser;
      tgt_fg   <= s_tdata[8]  ? cur_fg : sde_pkg::clamp_digit(s_tdata[3:0]);
      tgt_bg   <= s_tdata[9]  ? cur_bg : sde_pkg::clamp_digit(s_tdata[7:4]);
      tgt_attr <= s_tdata[10] ? cur_attr : s_tdata[14:11];
    end else if (go && ctl.act == sde_pkg::A_POP) begin
      tgt_fg   <= rd_data[3:0];
      tgt_bg   <= rd_data[7:4];
      tgt_attr <= rd_data[11:8];
    end
  end

  // Current state, separator flag, stack count
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_fg   <= sde_pkg::FG_RESET;
      cur_bg   <= sde_pkg::BG_RESET;
      cur_attr <= '0;
      count    <= '0;
      need_sep <= 1'b0;
    end else if (go) begin
      case (ctl.act)
        sde_pkg::A_PUT, sde_pkg::A_END: begin
          cur_fg   <= tgt_fg;
          cur_bg   <= tgt_bg;
          cur_attr <= tgt_attr;
        end
        sde_pkg::A_START: need_sep <= 1'b0;
        sde_pkg::A_SEP:   need_sep <= 1'b1;
        sde_pkg::A_PUSH:  count <= count + 1'b1;
        sde_pkg::A_POP:   count <= count_m1;
        default: ;
      endcase
    end
  end

  // Stack memory, read port registered every cycle at the top entry
  always_ff @(posedge clk) begin
    if (go && ctl.act == sde_pkg::A_PUSH) begin
      mem[count[IDX_W-1:0]] <= {cur_attr, cur_bg, cur_fg};
    end
    rd_data <= mem[count_m1[IDX_W-1:0]];
  end

  // Byte select
  always_comb begin
    byte_next = ctl.arg;
    last_next = 1'b0;
    err_next  = 1'b0;
    case (ctl.act)
      sde_pkg::A_SEP:        byte_next = sde_pkg::CH_SEMI;
      sde_pkg::A_FLAG_FIRST: byte_next = tgt_attr[fidx] ? sde_pkg::on_char(fidx)
                                                         : sde_pkg::CH_TWO;
      sde_pkg::A_FLAG_OFF:   byte_next = sde_pkg::off_char(fidx);
      sde_pkg::A_FG_DIG:     byte_next = sde_pkg::CH_ZERO + {4'd0, tgt_fg};
      sde_pkg::A_BG_DIG:     byte_next = sde_pkg::CH_ZERO + {4'd0, tgt_bg};
      sde_pkg::A_END:        last_next = 1'b1;
      sde_pkg::A_ERR: begin
        byte_next = sde_pkg::CH_NUL;
        last_next = 1'b1;
        err_next  = 1'b1;
      end
      default: ;
    endcase
  end

  // A separator step only writes when a parameter came before
  assign emit_now = go && sde_pkg::is_emit(ctl.act) &&
                    ((ctl.act != sde_pkg::A_SEP) || need_sep);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_now) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      m_tdata <= byte_next;
      m_tlast <= last_next;
      m_tuser <= err_next;
    end
  end

  // Status for the sequencer
  always_comb begin
    sts.item_valid = s_tvalid;
    sts.disabled   = !colors_enabled;
    sts.kind       = kind;
    sts.empty      = (count == '0);
    sts.full       = (count == CNT_W'(STACK_DEPTH));
    sts.no_change  = (tgt_fg == cur_fg) && (tgt_bg == cur_bg) && (tgt_attr == cur_attr);
    sts.flag_same  = tgt_attr ~^ cur_attr;
    sts.flag_on    = tgt_attr;
    sts.fg_same    = (tgt_fg == cur_fg);
    sts.bg_same    = (tgt_bg == cur_bg);
    sts.slot_free  = !m_tvalid || m_tready;
  end

endmodule

`default_nettype wire

FILE: src/sgr_delta_emitter_core.sv
// SGR delta emitter. Keeps a terminal's foreground, background and four
// attribute flags and turns each change into the shortest ECMA-48 SGR escape
// sequence, one byte per output item, tlast on the closing 'm'. A stack of
// STACK_DEPTH entries saves and restores the state; push on a full or pull on
// an empty stack returns one item with tuser set, data zero and tlast high.
// Control is a 40-step microprogram read from a ROM, one control word per
// cycle unless a byte step stalls on the output side, so the step walk sets
// the rate. A new item is taken only after the previous one has left the
// program, while its last byte may still sit in the output register.
`timescale 1ns / 1ps
`default_nettype none

module sgr_delta_emitter_core #(
  parameter int STACK_DEPTH = sde_pkg::DEF_STACK_DEPTH
) (
  input  wire         clk,
  input  wire         rst,
  // register port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  wire         s_tvalid,
  output logic        s_tready,
  // fg_code[3:0], bg_code[7:4], keep_fg[8], keep_bg[9], keep_attr[10],
  // want_bold[11], want_underscore[12], want_blink[13], want_reverse[14], 0[15]
  input  wire  [15:0] s_tdata,
  input  wire  [1:0]  s_tuser,   // kind[1:0]
  // output items
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic        m_tlast,   // last_byte
  output logic [0:0]  m_tuser    // stack_error[0]
);

  logic          colors_enabled;
  logic          reg0_hit;
  sde_pkg::ctl_t ctl;
  sde_pkg::sts_t sts;
  logic          go;

  // Register file: colors_enabled at offset 0
  assign pready   = 1'b1;
  assign reg0_hit = (paddr[2] == 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      colors_enabled <= 1'b1;
    end else if (psel && penable && pwrite && pready && reg0_hit) begin
      colors_enabled <= pwdata[0];
    end
  end

  assign prdata = reg0_hit ? {31'd0, colors_enabled} : 32'd0;

  sde_sequencer u_seq (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .ctl (ctl),
    .go  (go)
  );

  sde_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .go             (go),
    .colors_enabled (colors_enabled),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .m_tuser        (m_tuser),
    .sts            (sts)
  );

`ifndef NO_ASSERTIONS
  // An error item carries a zero byte and closes its run
  a_err_item: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == sde_pkg::CH_NUL))
    else $error("error item with bad payload");

  // A normal run always closes on 'm'
  a_close: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast && !m_tuser[0] |-> (m_tdata == sde_pkg::CH_M))
    else $error("run closed on a byte other than m");

  // The program never pushes onto a full stack or pops an empty one
  a_stack: assert property (@(posedge clk) disable iff (rst)
    go && ((ctl.act == sde_pkg::A_PUSH && sts.full) ||
           (ctl.act == sde_pkg::A_POP && sts.empty)) |-> 1'b0)
    else $error("stack overflow or underflow");

  // No input is taken while a byte step is stalled
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !go |-> !s_tready)
    else $error("input ready during stalled emit step");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_sgr_delta_emitter_core.sv
`timescale 1ns / 1ps

module tb_sgr_delta_emitter_core;

  localparam int SAVE_DEPTH = sde_pkg::DEF_STACK_DEPTH;
  localparam int CYCLE_LIMIT = 500000;
  // Cycles to let a silent item (put, push, ignored) leave the block
  localparam int SETTLE_CYCLES = 50;
  localparam logic [2:0] REG_COLORS_ENABLED = 3'd0;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] data;
  } sgr_req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } sgr_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic [0:0]  m_tuser;

  sgr_delta_emitter_core #(
    .STACK_DEPTH(SAVE_DEPTH)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  always #5 clk = ~clk;

  // Terminal state as the block should hold it
  logic       colors_on = 1'b1;
  logic [3:0] cur_fg = sde_pkg::FG_RESET;
  logic [3:0] cur_bg = sde_pkg::BG_RESET;
  logic [3:0] cur_attr = 4'd0;
  logic [11:0] saved_stack [SAVE_DEPTH];
  int         saved_depth = 0;
  bit         need_semi;

  sgr_req_t   pending_reqs[$];
  sgr_byte_t  expected_bytes[$];
  sgr_req_t   next_req;
  sgr_byte_t  want_b;
  int         err_count = 0;
  int         cycle_count = 0;
  logic       in_fire = 1'b0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         stall_mode = 0;
  int         stall_cnt = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    err_count++;
  endtask

  task automatic expect_byte(input logic [7:0] ch, input logic last, input logic err);
    sgr_byte_t b;
    b.ch   = ch;
    b.last = last;
    b.err  = err;
    expected_bytes.push_back(b);
  endtask

  task automatic emit_semi();
    if (need_semi) expect_byte(sde_pkg::CH_SEMI, 1'b0, 1'b0);
    need_semi = 1'b1;
  endtask

  function automatic logic [3:0] to_digit(input logic [3:0] v);
    return (v > sde_pkg::DIGIT_DEFAULT) ? sde_pkg::DIGIT_DEFAULT : v;
  endfunction

  // Shortest SGR run from the current state to the target; adopts the target
  task automatic sgr_move_to(input logic [3:0] fg, input logic [3:0] bg,
                             input logic [3:0] at);
    logic [7:0] set_ch [4];
    logic [7:0] clr_ch [4];
    set_ch = '{sde_pkg::CH_ONE, sde_pkg::CH_FOUR, sde_pkg::CH_FIVE, sde_pkg::CH_SEVEN};
    clr_ch = '{sde_pkg::CH_TWO, sde_pkg::CH_FOUR, sde_pkg::CH_FIVE, sde_pkg::CH_SEVEN};
    if (fg == cur_fg && bg == cur_bg && at == cur_attr) return;
    need_semi = 1'b0;
    expect_byte(sde_pkg::CH_ESC, 1'b0, 1'b0);
    expect_byte(sde_pkg::CH_LBR, 1'b0, 1'b0);
    for (int i = 0; i < 4; i++) begin
      if (at[i] && !cur_attr[i]) begin
        emit_semi();
        expect_byte(set_ch[i], 1'b0, 1'b0);
      end else if (!at[i] && cur_attr[i]) begin
        emit_semi();
        expect_byte(sde_pkg::CH_TWO, 1'b0, 1'b0);
        expect_byte(clr_ch[i], 1'b0, 1'b0);
      end
    end
    cur_attr = at;
    if (fg != cur_fg) begin
      emit_semi();
      expect_byte(sde_pkg::CH_THREE, 1'b0, 1'b0);
      expect_byte(sde_pkg::CH_ZERO + {4'd0, fg}, 1'b0, 1'b0);
      cur_fg = fg;
    end
    if (bg != cur_bg) begin
      emit_semi();
      expect_byte(sde_pkg::CH_FOUR, 1'b0, 1'b0);
      expect_byte(sde_pkg::CH_ZERO + {4'd0, bg}, 1'b0, 1'b0);
      cur_bg = bg;
    end
    expect_byte(sde_pkg::CH_M, 1'b1, 1'b0);
  endtask

  // Expected bytes for one accepted item
  task automatic sgr_predict(input logic [1:0] kind, input logic [15:0] d);
    logic [3:0] fg;
    logic [3:0] bg;
    logic [3:0] at;
    logic [11:0] top;
    if (!colors_on) return;
    fg = d[8] ? cur_fg : to_digit(d[3:0]);
    bg = d[9] ? cur_bg : to_digit(d[7:4]);
    at = d[10] ? cur_attr : d[14:11];
    case (kind)
      sde_pkg::KIND_SET: sgr_move_to(fg, bg, at);
      sde_pkg::KIND_PUT: begin
        cur_fg   = fg;
        cur_bg   = bg;
        cur_attr = at;
      end
      sde_pkg::KIND_PUSH: begin
        if (saved_depth >= SAVE_DEPTH) begin
          expect_byte(sde_pkg::CH_NUL, 1'b1, 1'b1);
        end else begin
          saved_stack[saved_depth] = {cur_fg, cur_bg, cur_attr};
          saved_depth++;
        end
      end
      default: begin
        if (saved_depth == 0) begin
          expect_byte(sde_pkg::CH_NUL, 1'b1, 1'b1);
        end else begin
          saved_depth--;
          top = saved_stack[saved_depth];
          sgr_move_to(top[11:8], top[7:4], top[3:0]);
        end
      end
    endcase
  endtask

  // Item builders
  task automatic queue_req(input logic [1:0] kind, input logic [3:0] fg,
                           input logic [3:0] bg, input logic kf, input logic kb,
                           input logic ka, input logic [3:0] at);
    sgr_req_t r;
    r.kind = kind;
    r.data = {1'b0, at, ka, kb, kf, bg, fg};
    pending_reqs.push_back(r);
  endtask

  function automatic logic [3:0] rand_code();
    return ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15))
                                       : 4'($urandom_range(0, 9));
  endfunction

  task automatic queue_rand_req(input logic [1:0] kind);
    queue_req(kind, rand_code(), rand_code(), $urandom_range(0, 3) == 0,
              $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
              4'($urandom_range(0, 15)));
  endtask

  // Mostly push / change / pull nests with random content, some loose items
  task automatic queue_random_mix(input int n_items);
    int made;
    int k;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 9) < 6) begin
        queue_rand_req(sde_pkg::KIND_PUSH);
        k = $urandom_range(1, 3);
        repeat (k) queue_rand_req(($urandom_range(0, 2) == 0) ? sde_pkg::KIND_PUT
                                                               : sde_pkg::KIND_SET);
        queue_rand_req(sde_pkg::KIND_PULL);
        made += k + 2;
      end else begin
        queue_rand_req(2'($urandom_range(0, 3)));
        made++;
      end
    end
  endtask

  // Drain the stack, overfill it, then pull it empty and once more
  task automatic queue_stack_storm();
    repeat (SAVE_DEPTH + 2) queue_rand_req(sde_pkg::KIND_PULL);
    repeat (SAVE_DEPTH + 1) begin
      queue_rand_req(sde_pkg::KIND_PUSH);
      if ($urandom_range(0, 1) == 0) queue_rand_req(sde_pkg::KIND_SET);
    end
    repeat (SAVE_DEPTH + 1) queue_rand_req(sde_pkg::KIND_PULL);
  endtask

  task automatic wait_drained(input int extra);
    while (pending_reqs.size() != 0 || s_tvalid || expected_bytes.size() != 0)
      @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == REG_COLORS_ENABLED) colors_on = value[0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Sender: bursts of items with random gaps between them
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        next_req = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_req.data;
        s_tuser  <= next_req.kind;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: picks a new random stall pattern whenever its counter runs out
  always @(negedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_cnt  <= 200;
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 3) != 0);
      2:       m_tready <= ((cycle_count % 7) < 4);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Predict on input handshakes, check on output handshakes
  always @(posedge clk) begin
    in_fire <= s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) sgr_predict(s_tuser, s_tdata);
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected item byte=%02h last=%b err=%b",
                                  m_tdata, m_tlast, m_tuser[0]));
      end else begin
        want_b = expected_bytes.pop_front();
        if (m_tdata !== want_b.ch)
          report_mismatch($sformatf("out_byte %02h, expected %02h", m_tdata, want_b.ch));
        if (m_tlast !== want_b.last)
          report_mismatch($sformatf("last_byte %b, expected %b", m_tlast, want_b.last));
        if (m_tuser[0] !== want_b.err)
          report_mismatch($sformatf("stack_error %b, expected %b", m_tuser[0], want_b.err));
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    reg_write(REG_COLORS_ENABLED, 32'd1);

    // Directed: extremes, every kind, clamped codes, stack edges
    queue_req(sde_pkg::KIND_SET, 4'd0, 4'd0, 0, 0, 0, 4'h0);
    queue_req(sde_pkg::KIND_SET, 4'd9, 4'd9, 0, 0, 0, 4'hF);
    queue_req(sde_pkg::KIND_SET, 4'd15, 4'd10, 0, 0, 0, 4'h0);
    queue_req(sde_pkg::KIND_SET, 4'd9, 4'd9, 0, 0, 0, 4'h0);
    queue_req(sde_pkg::KIND_PULL, 4'd0, 4'd0, 0, 0, 0, 4'h0);
    queue_req(sde_pkg::KIND_PUSH, 4'd1, 4'd2, 0, 0, 0, 4'h5);
    queue_req(sde_pkg::KIND_PUT, 4'd3, 4'd5, 0, 0, 0, 4'h9);
    queue_req(sde_pkg::KIND_PUT, 4'd0, 4'd0, 1, 1, 1, 4'h6);
    queue_req(sde_pkg::KIND_SET, 4'd4, 4'd2, 1, 0, 1, 4'h0);
    queue_req(sde_pkg::KIND_PULL, 4'd15, 4'd15, 1, 1, 1, 4'hF);
    queue_req(sde_pkg::KIND_PUSH, 4'd0, 4'd0, 0, 0, 0, 4'h0);
    queue_req(sde_pkg::KIND_PULL, 4'd0, 4'd0, 0, 0, 0, 4'h0);
    queue_req(sde_pkg::KIND_PULL, 4'd7, 4'd7, 0, 0, 0, 4'hF);
    queue_req(sde_pkg::KIND_SET, 4'd1, 4'd8, 0, 0, 0, 4'h1);
    queue_req(sde_pkg::KIND_SET, 4'd1, 4'd8, 0, 0, 0, 4'h2);
    queue_req(sde_pkg::KIND_SET, 4'd1, 4'd8, 0, 0, 0, 4'h4);
    queue_req(sde_pkg::KIND_SET, 4'd1, 4'd8, 0, 0, 0, 4'h8);
    queue_req(sde_pkg::KIND_SET, 4'd12, 4'd14, 0, 1, 1, 4'h7);
    queue_req(sde_pkg::KIND_SET, 4'd0, 4'd0, 0, 0, 1, 4'h0);
    queue_req(sde_pkg::KIND_PUT, 4'd15, 4'd15, 0, 0, 0, 4'hF);
    queue_req(sde_pkg::KIND_SET, 4'd7, 4'd0, 0, 0, 0, 4'h0);
    wait_drained(SETTLE_CYCLES);

    // Random, with one full drain halfway
    queue_random_mix(20);
    queue_stack_storm();
    wait_drained(0);
    queue_random_mix(20);
    wait_drained(SETTLE_CYCLES);

    // Colors off: every item must be ignored
    reg_write(REG_COLORS_ENABLED, 32'd0);
    repeat (12) queue_rand_req(2'($urandom_range(0, 3)));
    wait_drained(SETTLE_CYCLES);
    reg_write(REG_COLORS_ENABLED, 32'd1);

    queue_random_mix(45);
    wait_drained(SETTLE_CYCLES);

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/sde_pkg.sv
src/sde_sequencer.sv
src/sde_datapath.sv
src/sgr_delta_emitter_core.sv
tb/tb_sgr_delta_emitter_core.sv
